// ===== hw/rtl/arpr_pkg.sv =====
// arpr_pkg: shared constants, codes and types for the arp resolver core
// depends on nothing; imported by every module under hw/rtl
package arpr_pkg;

   localparam int CACHE_ENTRIES = 16;
   localparam int WAIT_ENTRIES  = 8;
   localparam int HANDLE_BITS   = 8;

   localparam int CIDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int WIDX_W = (WAIT_ENTRIES > 1) ? $clog2(WAIT_ENTRIES) : 1;
   localparam int SCAN_W = (CIDX_W > WIDX_W) ? CIDX_W : WIDX_W;

   localparam int MAC_W = 48;
   localparam int IP_W  = 32;
   localparam int AGE_W = 16;
   localparam int HDL_W = 8;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam logic [MAC_W-1:0] MAC_ONES = {MAC_W{1'b1}};
   localparam logic [AGE_W-1:0] AGE_MAX  = {AGE_W{1'b1}};
   localparam logic [AGE_W-1:0] CACHE_LIFE_RST = AGE_W'(30 * 1000);
   localparam logic [AGE_W-1:0] WAIT_LIFE_RST  = AGE_W'(5 * 1000);

   localparam logic [1:0] CMD_SEND  = 2'd0;
   localparam logic [1:0] CMD_FRAME = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [1:0] KIND_IPV4 = 2'd0;
   localparam logic [1:0] KIND_ARP  = 2'd1;

   localparam logic [1:0] ACT_IPV4    = 2'd0;
   localparam logic [1:0] ACT_ARP_REQ = 2'd1;
   localparam logic [1:0] ACT_ARP_RPL = 2'd2;
   localparam logic [1:0] ACT_DELIVER = 2'd3;

   localparam logic [1:0] REG_OWN_MAC    = 2'd0;
   localparam logic [1:0] REG_OWN_IP     = 2'd1;
   localparam logic [1:0] REG_CACHE_LIFE = 2'd2;
   localparam logic [1:0] REG_WAIT_LIFE  = 2'd3;

   typedef logic [HANDLE_BITS-1:0] hdl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CSCAN,
      ST_CDONE,
      ST_WSCAN,
      ST_WDONE,
      ST_CAGE,
      ST_WAGE
   } state_type;

   typedef enum logic [1:0] {
      OP_SEND,
      OP_ARP_REQ,
      OP_ARP_RPL,
      OP_TICK
   } op_type;

   typedef struct packed {
      logic [MAC_W-1:0] own_mac;
      logic [IP_W-1:0]  own_ip;
      logic [AGE_W-1:0] cache_life;
      logic [AGE_W-1:0] wait_life;
   } cfg_type;

   typedef struct packed {
      logic [IP_W-1:0]  key;
      logic [IP_W-1:0]  ent_ip;
      logic             ent_valid;
      logic [AGE_W-1:0] ent_age;
      logic [AGE_W-1:0] best_age;
      logic [AGE_W-1:0] addend;
      logic [AGE_W-1:0] lifetime;
   } unit_in_type;

   typedef struct packed {
      logic             match;
      logic             older;
      logic [AGE_W-1:0] new_age;
      logic             expire;
   } unit_out_type;

endpackage

// ===== hw/rtl/arp_resolver_with_aging_core.sv =====
// arp_resolver_with_aging_core: top level, scan sequencer and both tables
// depends on arpr_pkg, arpr_csr, arpr_unit
//
// channel   | handshake             | payload
// ----------+-----------------------+-----------------------------------------
// request   | start / busy          | req_cmd .. req_elapsed_ms
// result    | rsp_valid (1 cycle)   | rsp_action .. rsp_handle_out
// registers | psel penable pwrite   | paddr pwdata prdata, pready tied high
//
// a frame to deliver or to ignore is answered from idle; a send scans the
// cache, then the wait table on a miss; an arp request scans the cache; an
// arp reply scans the cache, then the wait table; a tick ages the cache, then
// the wait table; the sequencer walks one table entry per cycle through the
// shared compare/age unit, and busy is high until it returns to idle
// reset clears valid bits, sequencer and registers; no clearing pass
// the result beat shows for one cycle and cannot be stalled
module arp_resolver_with_aging_core import arpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_cmd,
   input  logic [IP_W-1:0]       req_next_hop_ip,
   input  logic [HDL_W-1:0]      req_payload_handle,
   input  logic [MAC_W-1:0]      req_frame_dst_mac,
   input  logic [1:0]            req_frame_kind,
   input  logic                  req_arp_is_reply,
   input  logic [IP_W-1:0]       req_arp_sender_ip,
   input  logic [MAC_W-1:0]      req_arp_sender_mac,
   input  logic [IP_W-1:0]       req_arp_target_ip,
   input  logic [AGE_W-1:0]      req_elapsed_ms,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_action,
   output logic [MAC_W-1:0]      rsp_dest_mac,
   output logic [IP_W-1:0]       rsp_arp_target_ip_out,
   output logic [MAC_W-1:0]      rsp_arp_target_mac_out,
   output logic [HDL_W-1:0]      rsp_handle_out,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type      cfg;
   unit_in_type  ui;
   unit_out_type uo;

   arpr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   arpr_unit u_unit (
      .ui (ui),
      .uo (uo)
   );

   // tables
   logic [CACHE_ENTRIES-1:0] cvalid_ff, cvalid_in;
   logic [IP_W-1:0]          cip_ff  [CACHE_ENTRIES];
   logic [MAC_W-1:0]         cmac_ff [CACHE_ENTRIES];
   logic [AGE_W-1:0]         cage_ff [CACHE_ENTRIES];
   logic [WAIT_ENTRIES-1:0]  wvalid_ff, wvalid_in;
   logic [IP_W-1:0]          wip_ff  [WAIT_ENTRIES];
   hdl_type                  whdl_ff [WAIT_ENTRIES];
   logic [AGE_W-1:0]         wage_ff [WAIT_ENTRIES];

   // table write controls
   logic              c_we, c_age_we, w_we, w_age_we;
   logic [CIDX_W-1:0] c_widx;
   logic [WIDX_W-1:0] w_widx;
   logic [AGE_W-1:0]  age_wval;

   // sequencer state
   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic [IP_W-1:0]   key_ff, key_in;
   logic [MAC_W-1:0]  smac_ff, smac_in;
   logic [IP_W-1:0]   tip_ff, tip_in;
   hdl_type           hdl_ff, hdl_in;
   logic [AGE_W-1:0]  elapsed_ff, elapsed_in;

   logic              c_hit_ff, c_hit_in;
   logic [CIDX_W-1:0] c_hit_idx_ff, c_hit_idx_in;
   logic [MAC_W-1:0]  c_mac_ff, c_mac_in;
   logic              c_free_ff, c_free_in;
   logic [CIDX_W-1:0] c_free_idx_ff, c_free_idx_in;
   logic [CIDX_W-1:0] c_old_idx_ff, c_old_idx_in;
   logic [AGE_W-1:0]  c_old_age_ff, c_old_age_in;
   logic              w_hit_ff, w_hit_in;
   logic [WIDX_W-1:0] w_hit_idx_ff, w_hit_idx_in;
   hdl_type           w_hdl_ff, w_hdl_in;
   logic              w_free_ff, w_free_in;
   logic [WIDX_W-1:0] w_free_idx_ff, w_free_idx_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_action_ff, rsp_action_in;
   logic [MAC_W-1:0] rsp_dmac_ff, rsp_dmac_in;
   logic [IP_W-1:0]  rsp_tip_ff, rsp_tip_in;
   logic [MAC_W-1:0] rsp_tmac_ff, rsp_tmac_in;
   logic [HDL_W-1:0] rsp_hdl_ff, rsp_hdl_in;

   logic [CIDX_W-1:0] cidx;
   logic [WIDX_W-1:0] widx;
   logic              c_last, w_last, for_us, in_wait;

   assign cidx    = scan_ff[CIDX_W-1:0];
   assign widx    = scan_ff[WIDX_W-1:0];
   assign c_last  = (cidx == CIDX_W'(CACHE_ENTRIES - 1));
   assign w_last  = (widx == WIDX_W'(WAIT_ENTRIES - 1));
   assign for_us  = (req_frame_dst_mac == cfg.own_mac) || (req_frame_dst_mac == MAC_ONES);
   assign in_wait = (state_ff == ST_WSCAN) || (state_ff == ST_WAGE);
   assign busy    = (state_ff != ST_IDLE);

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_action             = rsp_action_ff;
   assign rsp_dest_mac           = rsp_dmac_ff;
   assign rsp_arp_target_ip_out  = rsp_tip_ff;
   assign rsp_arp_target_mac_out = rsp_tmac_ff;
   assign rsp_handle_out         = rsp_hdl_ff;

   // operand select for the shared unit
   always_comb begin
      ui.key      = key_ff;
      ui.best_age = c_old_age_ff;
      ui.addend   = elapsed_ff;
      if (in_wait) begin
         ui.ent_ip    = wip_ff[widx];
         ui.ent_valid = wvalid_ff[widx];
         ui.ent_age   = wage_ff[widx];
         ui.lifetime  = cfg.wait_life;
      end else begin
         ui.ent_ip    = cip_ff[cidx];
         ui.ent_valid = cvalid_ff[cidx];
         ui.ent_age   = cage_ff[cidx];
         ui.lifetime  = cfg.cache_life;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      scan_in       = scan_ff;
      key_in        = key_ff;
      smac_in       = smac_ff;
      tip_in        = tip_ff;
      hdl_in        = hdl_ff;
      elapsed_in    = elapsed_ff;
      c_hit_in      = c_hit_ff;
      c_hit_idx_in  = c_hit_idx_ff;
      c_mac_in      = c_mac_ff;
      c_free_in     = c_free_ff;
      c_free_idx_in = c_free_idx_ff;
      c_old_idx_in  = c_old_idx_ff;
      c_old_age_in  = c_old_age_ff;
      w_hit_in      = w_hit_ff;
      w_hit_idx_in  = w_hit_idx_ff;
      w_hdl_in      = w_hdl_ff;
      w_free_in     = w_free_ff;
      w_free_idx_in = w_free_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_action_in = rsp_action_ff;
      rsp_dmac_in   = rsp_dmac_ff;
      rsp_tip_in    = rsp_tip_ff;
      rsp_tmac_in   = rsp_tmac_ff;
      rsp_hdl_in    = rsp_hdl_ff;
      cvalid_in     = cvalid_ff;
      wvalid_in     = wvalid_ff;
      c_we          = 1'b0;
      c_age_we      = 1'b0;
      w_we          = 1'b0;
      w_age_we      = 1'b0;
      c_widx        = cidx;
      w_widx        = widx;
      age_wval      = uo.new_age;

      case (state_ff)
         ST_IDLE: begin
            scan_in   = '0;
            c_hit_in  = 1'b0;
            c_free_in = 1'b0;
            if (start) begin
               case (req_cmd)
                  CMD_SEND: begin
                     op_in    = OP_SEND;
                     key_in   = req_next_hop_ip;
                     hdl_in   = hdl_type'(req_payload_handle);
                     state_in = ST_CSCAN;
                  end
                  CMD_FRAME: begin
                     if (for_us && req_frame_kind == KIND_IPV4) begin
                        rsp_valid_in  = 1'b1;
                        rsp_action_in = ACT_DELIVER;
                        rsp_dmac_in   = '0;
                        rsp_tip_in    = '0;
                        rsp_tmac_in   = '0;
                        rsp_hdl_in    = HDL_W'(hdl_type'(req_payload_handle));
                     end else if (for_us && req_frame_kind == KIND_ARP) begin
                        op_in    = req_arp_is_reply ? OP_ARP_RPL : OP_ARP_REQ;
                        key_in   = req_arp_sender_ip;
                        smac_in  = req_arp_sender_mac;
                        tip_in   = req_arp_target_ip;
                        state_in = ST_CSCAN;
                     end
                  end
                  CMD_TICK: begin
                     op_in      = OP_TICK;
                     elapsed_in = req_elapsed_ms;
                     state_in   = ST_CAGE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_CSCAN: begin
            if (uo.match && !c_hit_ff) begin
               c_hit_in     = 1'b1;
               c_hit_idx_in = cidx;
               c_mac_in     = cmac_ff[cidx];
            end
            if (!cvalid_ff[cidx] && !c_free_ff) begin
               c_free_in     = 1'b1;
               c_free_idx_in = cidx;
            end
            // oldest entry, lowest index wins a tie
            if (cidx == '0 || uo.older) begin
               c_old_idx_in = cidx;
               c_old_age_in = ui.ent_age;
            end
            if (c_last) begin
               state_in = ST_CDONE;
            end else begin
               scan_in = scan_ff + SCAN_W'(1);
            end
         end

         ST_CDONE: begin
            scan_in   = '0;
            w_hit_in  = 1'b0;
            w_free_in = 1'b0;
            if (op_ff == OP_SEND) begin
               if (c_hit_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_action_in = ACT_IPV4;
                  rsp_dmac_in   = c_mac_ff;
                  rsp_tip_in    = '0;
                  rsp_tmac_in   = '0;
                  rsp_hdl_in    = HDL_W'(hdl_ff);
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_WSCAN;
               end
            end else begin
               // learn: existing entry, else first free, else oldest
               c_we   = 1'b1;
               c_widx = c_hit_ff ? c_hit_idx_ff : (c_free_ff ? c_free_idx_ff : c_old_idx_ff);
               cvalid_in[c_widx] = 1'b1;
               if (op_ff == OP_ARP_REQ) begin
                  if (tip_ff == cfg.own_ip) begin
                     rsp_valid_in  = 1'b1;
                     rsp_action_in = ACT_ARP_RPL;
                     rsp_dmac_in   = smac_ff;
                     rsp_tip_in    = key_ff;
                     rsp_tmac_in   = smac_ff;
                     rsp_hdl_in    = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_WSCAN;
               end
            end
         end

         ST_WSCAN: begin
            if (uo.match && !w_hit_ff) begin
               w_hit_in     = 1'b1;
               w_hit_idx_in = widx;
               w_hdl_in     = whdl_ff[widx];
            end
            if (!wvalid_ff[widx] && !w_free_ff) begin
               w_free_in     = 1'b1;
               w_free_idx_in = widx;
            end
            if (w_last) begin
               state_in = ST_WDONE;
            end else begin
               scan_in = scan_ff + SCAN_W'(1);
            end
         end

         ST_WDONE: begin
            state_in = ST_IDLE;
            if (op_ff == OP_SEND) begin
               if (!w_hit_ff && w_free_ff) begin
                  w_we   = 1'b1;
                  w_widx = w_free_idx_ff;
                  wvalid_in[w_widx] = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_action_in = ACT_ARP_REQ;
                  rsp_dmac_in   = MAC_ONES;
                  rsp_tip_in    = key_ff;
                  rsp_tmac_in   = '0;
                  rsp_hdl_in    = '0;
               end
            end else if (w_hit_ff) begin
               wvalid_in[w_hit_idx_ff] = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_action_in = ACT_IPV4;
               rsp_dmac_in   = smac_ff;
               rsp_tip_in    = '0;
               rsp_tmac_in   = '0;
               rsp_hdl_in    = HDL_W'(w_hdl_ff);
            end
         end

         ST_CAGE: begin
            if (cvalid_ff[cidx]) begin
               c_age_we = 1'b1;
               if (uo.expire) begin
                  cvalid_in[cidx] = 1'b0;
               end
            end
            if (c_last) begin
               scan_in  = '0;
               state_in = ST_WAGE;
            end else begin
               scan_in = scan_ff + SCAN_W'(1);
            end
         end

         ST_WAGE: begin
            if (wvalid_ff[widx]) begin
               w_age_we = 1'b1;
               if (uo.expire) begin
                  wvalid_in[widx] = 1'b0;
               end
            end
            if (w_last) begin
               scan_in  = '0;
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + SCAN_W'(1);
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_SEND;
         scan_ff      <= '0;
         cvalid_ff    <= '0;
         wvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         c_hit_ff     <= 1'b0;
         c_free_ff    <= 1'b0;
         w_hit_ff     <= 1'b0;
         w_free_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         scan_ff      <= scan_in;
         cvalid_ff    <= cvalid_in;
         wvalid_ff    <= wvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         c_hit_ff     <= c_hit_in;
         c_free_ff    <= c_free_in;
         w_hit_ff     <= w_hit_in;
         w_free_ff    <= w_free_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      smac_ff       <= smac_in;
      tip_ff        <= tip_in;
      hdl_ff        <= hdl_in;
      elapsed_ff    <= elapsed_in;
      c_hit_idx_ff  <= c_hit_idx_in;
      c_mac_ff      <= c_mac_in;
      c_free_idx_ff <= c_free_idx_in;
      c_old_idx_ff  <= c_old_idx_in;
      c_old_age_ff  <= c_old_age_in;
      w_hit_idx_ff  <= w_hit_idx_in;
      w_hdl_ff      <= w_hdl_in;
      w_free_idx_ff <= w_free_idx_in;
      rsp_action_ff <= rsp_action_in;
      rsp_dmac_ff   <= rsp_dmac_in;
      rsp_tip_ff    <= rsp_tip_in;
      rsp_tmac_ff   <= rsp_tmac_in;
      rsp_hdl_ff    <= rsp_hdl_in;
   end

   // cache payload
   always_ff @(posedge clock) begin
      if (c_we) begin
         cip_ff[c_widx]  <= key_ff;
         cmac_ff[c_widx] <= smac_ff;
         cage_ff[c_widx] <= '0;
      end else if (c_age_we) begin
         cage_ff[c_widx] <= age_wval;
      end
   end

   // wait table payload
   always_ff @(posedge clock) begin
      if (w_we) begin
         wip_ff[w_widx]  <= key_ff;
         whdl_ff[w_widx] <= hdl_ff;
         wage_ff[w_widx] <= '0;
      end else if (w_age_we) begin
         wage_ff[w_widx] <= age_wval;
      end
   end

`ifndef SYNTHESIS
   a_tick_ages: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_TICK) |=> (state_ff == ST_CAGE))
      else $error("tick did not start the aging scan");

   a_req_bcast: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_ARP_REQ) |->
      (rsp_dest_mac == MAC_ONES && rsp_handle_out == '0))
      else $error("arp request beat not broadcast");

   a_pending_drop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WDONE && op_ff == OP_SEND && w_hit_ff) |=> !rsp_valid)
      else $error("send with pending wait produced a beat");

   a_aging_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CAGE || state_ff == ST_WAGE) |=> !rsp_valid)
      else $error("aging scan produced a beat");
`endif

endmodule

// ===== hw/rtl/arpr_csr.sv =====
// arpr_csr: apb register file for own addresses and table lifetimes
// depends on arpr_pkg
module arpr_csr import arpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:3];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_OWN_MAC:    cfg_in.own_mac    = pwdata[MAC_W-1:0];
            REG_OWN_IP:     cfg_in.own_ip     = pwdata[IP_W-1:0];
            REG_CACHE_LIFE: cfg_in.cache_life = pwdata[AGE_W-1:0];
            REG_WAIT_LIFE:  cfg_in.wait_life  = pwdata[AGE_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_OWN_MAC:    prdata = CSR_DATA_W'(cfg_ff.own_mac);
         REG_OWN_IP:     prdata = CSR_DATA_W'(cfg_ff.own_ip);
         REG_CACHE_LIFE: prdata = CSR_DATA_W'(cfg_ff.cache_life);
         REG_WAIT_LIFE:  prdata = CSR_DATA_W'(cfg_ff.wait_life);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_mac    <= '0;
         cfg_ff.own_ip     <= '0;
         cfg_ff.cache_life <= CACHE_LIFE_RST;
         cfg_ff.wait_life  <= WAIT_LIFE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/arpr_unit.sv =====
// arpr_unit: shared compare and saturating age unit used by every table scan
// depends on arpr_pkg
module arpr_unit import arpr_pkg::*; (
   input  unit_in_type  ui,
   output unit_out_type uo
);

   logic [AGE_W:0] sum;

   always_comb begin
      sum        = {1'b0, ui.ent_age} + {1'b0, ui.addend};
      uo.match   = ui.ent_valid && (ui.ent_ip == ui.key);
      uo.older   = ui.ent_age > ui.best_age;
      uo.new_age = sum[AGE_W] ? AGE_MAX : sum[AGE_W-1:0];
      uo.expire  = uo.new_age >= ui.lifetime;
   end

endmodule

// ===== test/arp_resolver_with_aging_core_test.sv =====
// arp_resolver_with_aging_core_test: self-checking bench for the arp resolver core
// depends on arpr_pkg and arp_resolver_with_aging_core; checks every result beat
// against an in-bench cache and pending-table predictor
`timescale 1ns / 100ps

module arp_resolver_with_aging_core_test;
   import arpr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 40;
   localparam int POOL_N      = 20;

   typedef struct {
      logic [1:0]       cmd;
      logic [IP_W-1:0]  hop;
      logic [HDL_W-1:0] handle;
      logic [MAC_W-1:0] dst;
      logic [1:0]       kind;
      logic             is_reply;
      logic [IP_W-1:0]  sip;
      logic [MAC_W-1:0] smac;
      logic [IP_W-1:0]  tip;
      logic [AGE_W-1:0] elapsed;
   } req_item_type;

   typedef struct {
      logic [1:0]       action;
      logic [MAC_W-1:0] mac;
      logic [IP_W-1:0]  tip;
      logic [MAC_W-1:0] tmac;
      logic [HDL_W-1:0] handle;
   } action_type;

   class arp_action_tracker;
      logic [MAC_W-1:0] own_mac;
      logic [IP_W-1:0]  own_ip;
      logic [AGE_W-1:0] cache_life;
      logic [AGE_W-1:0] wait_life;
      bit               c_vld[CACHE_ENTRIES];
      logic [IP_W-1:0]  c_ip[CACHE_ENTRIES];
      logic [MAC_W-1:0] c_mac[CACHE_ENTRIES];
      logic [AGE_W-1:0] c_age[CACHE_ENTRIES];
      bit               w_vld[WAIT_ENTRIES];
      logic [IP_W-1:0]  w_ip[WAIT_ENTRIES];
      logic [HDL_W-1:0] w_hdl[WAIT_ENTRIES];
      logic [AGE_W-1:0] w_age[WAIT_ENTRIES];
      action_type       actions_due[$];
      int               mismatches;

      function new();
         own_mac    = '0;
         own_ip     = '0;
         cache_life = CACHE_LIFE_RST;
         wait_life  = WAIT_LIFE_RST;
         foreach (c_vld[i]) c_vld[i] = 0;
         foreach (w_vld[i]) w_vld[i] = 0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [63:0] v);
         case (idx)
            REG_OWN_MAC:    own_mac = v[MAC_W-1:0];
            REG_OWN_IP:     own_ip = v[IP_W-1:0];
            REG_CACHE_LIFE: cache_life = v[AGE_W-1:0];
            REG_WAIT_LIFE:  wait_life = v[AGE_W-1:0];
            default: ;
         endcase
      endfunction

      function int find_cache(logic [IP_W-1:0] ip);
         for (int i = 0; i < CACHE_ENTRIES; i++)
            if (c_vld[i] && c_ip[i] == ip) return i;
         return -1;
      endfunction

      function int find_wait(logic [IP_W-1:0] ip);
         for (int i = 0; i < WAIT_ENTRIES; i++)
            if (w_vld[i] && w_ip[i] == ip) return i;
         return -1;
      endfunction

      function void learn(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
         int slot;
         slot = find_cache(ip);
         if (slot < 0) begin
            for (int i = 0; i < CACHE_ENTRIES; i++)
               if (!c_vld[i]) begin
                  slot = i;
                  break;
               end
         end
         // full: evict oldest, lowest index on a tie
         if (slot < 0) begin
            slot = 0;
            for (int i = 1; i < CACHE_ENTRIES; i++)
               if (c_age[i] > c_age[slot]) slot = i;
         end
         c_vld[slot] = 1;
         c_ip[slot]  = ip;
         c_mac[slot] = mac;
         c_age[slot] = '0;
      endfunction

      function logic [AGE_W-1:0] sat_add(logic [AGE_W-1:0] a, logic [AGE_W-1:0] d);
         logic [AGE_W:0] s;
         s = {1'b0, a} + {1'b0, d};
         return s[AGE_W] ? AGE_MAX : s[AGE_W-1:0];
      endfunction

      function void push(logic [1:0] act, logic [MAC_W-1:0] mac, logic [IP_W-1:0] tip,
                         logic [MAC_W-1:0] tmac, logic [HDL_W-1:0] hdl);
         action_type a;
         a.action = act;
         a.mac    = mac;
         a.tip    = tip;
         a.tmac   = tmac;
         a.handle = hdl;
         actions_due.push_back(a);
      endfunction

      function void note_request(req_item_type it);
         int c;
         int w;
         if (it.cmd == CMD_SEND) begin
            c = find_cache(it.hop);
            if (c >= 0) begin
               push(ACT_IPV4, c_mac[c], '0, '0, it.handle);
               return;
            end
            if (find_wait(it.hop) >= 0) return;
            for (int i = 0; i < WAIT_ENTRIES; i++)
               if (!w_vld[i]) begin
                  w_vld[i] = 1;
                  w_ip[i]  = it.hop;
                  w_hdl[i] = it.handle;
                  w_age[i] = '0;
                  push(ACT_ARP_REQ, MAC_ONES, it.hop, '0, '0);
                  return;
               end
         end else if (it.cmd == CMD_FRAME) begin
            if (it.dst != own_mac && it.dst != MAC_ONES) return;
            if (it.kind == KIND_IPV4) begin
               push(ACT_DELIVER, '0, '0, '0, it.handle);
               return;
            end
            if (it.kind != KIND_ARP) return;
            learn(it.sip, it.smac);
            if (!it.is_reply) begin
               if (it.tip == own_ip) push(ACT_ARP_RPL, it.smac, it.sip, it.smac, '0);
               return;
            end
            w = find_wait(it.sip);
            if (w < 0) return;
            w_vld[w] = 0;
            push(ACT_IPV4, it.smac, '0, '0, w_hdl[w]);
         end else if (it.cmd == CMD_TICK) begin
            for (int i = 0; i < CACHE_ENTRIES; i++)
               if (c_vld[i]) begin
                  c_age[i] = sat_add(c_age[i], it.elapsed);
                  if (c_age[i] >= cache_life) c_vld[i] = 0;
               end
            for (int i = 0; i < WAIT_ENTRIES; i++)
               if (w_vld[i]) begin
                  w_age[i] = sat_add(w_age[i], it.elapsed);
                  if (w_age[i] >= wait_life) w_vld[i] = 0;
               end
         end
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_action(action_type got);
         action_type exp;
         if (actions_due.size() == 0) begin
            report($sformatf("result beat with nothing expected, action %0d", got.action));
            return;
         end
         exp = actions_due.pop_front();
         if (got.action !== exp.action)
            report($sformatf("action got %0d exp %0d", got.action, exp.action));
         if (got.mac !== exp.mac)
            report($sformatf("dest_mac got %h exp %h", got.mac, exp.mac));
         if (got.tip !== exp.tip)
            report($sformatf("arp_target_ip_out got %h exp %h", got.tip, exp.tip));
         if (got.tmac !== exp.tmac)
            report($sformatf("arp_target_mac_out got %h exp %h", got.tmac, exp.tmac));
         if (got.handle !== exp.handle)
            report($sformatf("handle_out got %h exp %h", got.handle, exp.handle));
      endtask
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  start = 0;
   logic                  busy;
   logic [1:0]            req_cmd = '0;
   logic [IP_W-1:0]       req_next_hop_ip = '0;
   logic [HDL_W-1:0]      req_payload_handle = '0;
   logic [MAC_W-1:0]      req_frame_dst_mac = '0;
   logic [1:0]            req_frame_kind = '0;
   logic                  req_arp_is_reply = 0;
   logic [IP_W-1:0]       req_arp_sender_ip = '0;
   logic [MAC_W-1:0]      req_arp_sender_mac = '0;
   logic [IP_W-1:0]       req_arp_target_ip = '0;
   logic [AGE_W-1:0]      req_elapsed_ms = '0;
   logic                  rsp_valid;
   logic [1:0]            rsp_action;
   logic [MAC_W-1:0]      rsp_dest_mac;
   logic [IP_W-1:0]       rsp_arp_target_ip_out;
   logic [MAC_W-1:0]      rsp_arp_target_mac_out;
   logic [HDL_W-1:0]      rsp_handle_out;
   logic                  psel = 0;
   logic                  penable = 0;
   logic                  pwrite = 0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   arp_action_tracker trk = new();
   logic [IP_W-1:0]   ip_pool[POOL_N];
   int                cycles = 0;

   arp_resolver_with_aging_core u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("arp_resolver_with_aging_core_test: done, errors");
         $finish;
      end
      if (!reset && rsp_valid)
         trk.check_action('{rsp_action, rsp_dest_mac, rsp_arp_target_ip_out,
                            rsp_arp_target_mac_out, rsp_handle_out});
   end

   function automatic logic [MAC_W-1:0] rand_mac();
      return MAC_W'({$urandom(), $urandom()});
   endfunction

   // every field random, then the caller overrides what matters
   function automatic req_item_type base_item(logic [1:0] cmd);
      req_item_type it;
      it.cmd      = cmd;
      it.hop      = $urandom();
      it.handle   = HDL_W'($urandom());
      it.dst      = rand_mac();
      it.kind     = 2'($urandom_range(3));
      it.is_reply = 1'($urandom_range(1));
      it.sip      = $urandom();
      it.smac     = rand_mac();
      it.tip      = $urandom();
      it.elapsed  = AGE_W'($urandom());
      return it;
   endfunction

   function automatic req_item_type mk_send(logic [IP_W-1:0] ip);
      req_item_type it;
      it     = base_item(CMD_SEND);
      it.hop = ip;
      return it;
   endfunction

   function automatic req_item_type mk_frame(logic [MAC_W-1:0] dst, logic [1:0] kind,
                                             logic rep, logic [IP_W-1:0] sip,
                                             logic [IP_W-1:0] tip);
      req_item_type it;
      it          = base_item(CMD_FRAME);
      it.dst      = dst;
      it.kind     = kind;
      it.is_reply = rep;
      it.sip      = sip;
      it.tip      = tip;
      return it;
   endfunction

   function automatic req_item_type rand_item();
      req_item_type it;
      int           r;
      int           d;
      r = $urandom_range(99);
      if (r < 35) begin
         it = mk_send(($urandom_range(9) == 0) ? $urandom() : ip_pool[$urandom_range(POOL_N-1)]);
      end else if (r < 75) begin
         it = base_item(CMD_FRAME);
         d  = $urandom_range(99);
         if (d < 45) it.dst = trk.own_mac;
         else if (d < 80) it.dst = MAC_ONES;
         d = $urandom_range(9);
         it.kind = (d == 0) ? KIND_IPV4 : (d == 9) ? 2'($urandom_range(2, 3)) : KIND_ARP;
         if ($urandom_range(99) < 85) it.sip = ip_pool[$urandom_range(POOL_N-1)];
         if ($urandom_range(1)) it.tip = trk.own_ip;
      end else if (r < 92) begin
         it = base_item(CMD_TICK);
         d  = $urandom_range(99);
         if (d < 50) it.elapsed = AGE_W'($urandom_range(trk.cache_life / 8));
         else if (d < 80) it.elapsed = AGE_W'($urandom_range(trk.wait_life / 4));
         else if (d < 90) it.elapsed = '0;
      end else begin
         it = base_item(2'd3);
      end
      return it;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
      psel    = 1;
      pwrite  = 1;
      penable = 0;
      paddr   = {idx, 3'b000};
      pwdata  = v;
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      trk.set_reg(idx, v);
      @(negedge clock);
      psel    = 0;
      penable = 0;
      pwrite  = 0;
   endtask

   task automatic issue(input req_item_type it, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start = 0;
         @(negedge clock);
      end
      req_cmd            = it.cmd;
      req_next_hop_ip    = it.hop;
      req_payload_handle = it.handle;
      req_frame_dst_mac  = it.dst;
      req_frame_kind     = it.kind;
      req_arp_is_reply   = it.is_reply;
      req_arp_sender_ip  = it.sip;
      req_arp_sender_mac = it.smac;
      req_arp_target_ip  = it.tip;
      req_elapsed_ms     = it.elapsed;
      start              = 1;
      do @(posedge clock); while (busy);
      trk.note_request(it);
      @(negedge clock);
   endtask

   // idle point: nothing due, core back in idle, longest latency let past
   task automatic drain();
      start = 0;
      while (trk.actions_due.size() != 0 || busy) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   initial begin
      logic [MAC_W-1:0] m;
      logic [IP_W-1:0]  a;
      logic [IP_W-1:0]  cip;
      int               idle_pct[3];
      idle_pct = '{38, 88, 0};

      repeat (10) @(negedge clock);
      reset = 0;
      @(negedge clock);

      // directed: lifetimes stay at their reset values here
      m = rand_mac();
      a = $urandom();
      cip = $urandom();
      write_reg(REG_OWN_MAC, 64'(m));
      write_reg(REG_OWN_IP, 64'(cip));
      issue(mk_send(a), 0);
      issue(mk_send(a), 0);
      issue(mk_frame(m, KIND_ARP, 1, a, $urandom()), 0);
      issue(mk_send(a), 0);
      issue(mk_frame(MAC_ONES, KIND_IPV4, 0, $urandom(), $urandom()), 0);
      issue(mk_frame(m, KIND_IPV4, 0, $urandom(), $urandom()), 0);
      issue(mk_frame(m ^ 48'h1, KIND_IPV4, 0, $urandom(), $urandom()), 0);
      issue(mk_frame(m, 2'd2, 1, $urandom(), cip), 0);
      issue(mk_frame(m, 2'd3, 0, $urandom(), cip), 0);
      issue(base_item(2'd3), 0);
      issue(mk_frame(MAC_ONES, KIND_ARP, 0, $urandom(), cip), 0);
      issue(mk_frame(m, KIND_ARP, 0, $urandom(), cip ^ 32'h1), 0);
      issue(mk_frame(m, KIND_ARP, 1, $urandom(), $urandom()), 0);
      // nine fresh misses overflow the pending table
      issue(mk_send('0), 0);
      issue(mk_send('1), 0);
      for (int i = 0; i < 7; i++) issue(mk_send($urandom()), 0);
      begin
         req_item_type t;
         t = base_item(CMD_TICK);
         t.elapsed = AGE_MAX;
         issue(t, 0);
      end
      issue(mk_send(a), 0);

      for (int ph = 0; ph < 3; ph++) begin
         drain();
         case (ph)
            0: begin
               write_reg(REG_OWN_MAC, 64'(rand_mac()));
               write_reg(REG_OWN_IP, 64'($urandom()));
               write_reg(REG_CACHE_LIFE, 64'($urandom_range(2000, 40000)));
               write_reg(REG_WAIT_LIFE, 64'($urandom_range(500, 8000)));
            end
            1: begin
               write_reg(REG_OWN_MAC, 64'(MAC_ONES));
               write_reg(REG_OWN_IP, 64'(0));
               write_reg(REG_CACHE_LIFE, 64'(AGE_MAX));
               write_reg(REG_WAIT_LIFE, 64'(1));
            end
            default: begin
               write_reg(REG_OWN_MAC, 64'(0));
               write_reg(REG_OWN_IP, 64'(32'hFFFF_FFFF));
               write_reg(REG_CACHE_LIFE, 64'(1));
               write_reg(REG_WAIT_LIFE, 64'(AGE_MAX));
            end
         endcase
         foreach (ip_pool[i]) ip_pool[i] = $urandom();
         for (int n = 0; n < 480; n++) issue(rand_item(), idle_pct[ph]);
      end

      drain();
      if (trk.actions_due.size() != 0) trk.report("expected results left over");
      if (trk.mismatches == 0) begin
         $display("arp_resolver_with_aging_core_test: done, clean");
      end else begin
         $display("arp_resolver_with_aging_core_test: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/arpr_pkg.sv
hw/rtl/arpr_csr.sv
hw/rtl/arpr_unit.sv
hw/rtl/arp_resolver_with_aging_core.sv
test/arp_resolver_with_aging_core_test.sv
